// ===== rtl/core/mfc_pkg.sv =====
// mfc_pkg: shared types and constants of the modbus frame classifier
// no dependencies; used by every module under rtl/core except mfc_fifo

package mfc_pkg;

  // frame kinds reported on the result side
  localparam logic [1:0] KIND_INVALID   = 2'd0;
  localparam logic [1:0] KIND_EXCEPTION = 2'd1;
  localparam logic [1:0] KIND_REQUEST   = 2'd2;
  localparam logic [1:0] KIND_RESPONSE  = 2'd3;

  // modbus function codes that the classifier knows
  localparam logic [7:0] FUNC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FUNC_READ_INPUT     = 8'h04;
  localparam logic [7:0] FUNC_WRITE_SINGLE   = 8'h06;
  localparam logic [7:0] FUNC_WRITE_MULTIPLE = 8'h10;

  // number of leading frame bytes kept
  localparam int HDR_DEPTH = 7;

  // register index decoded from paddr[2]
  localparam logic REG_BROADCAST_ADDRESS = 1'b0;

  // one complete frame as handed from the front to the back
  typedef struct packed {
    logic [HDR_DEPTH-1:0][7:0] hdr;   // header bytes, zero beyond frame length
    logic [7:0]                len;   // frame length, valid when over is low
    logic                      over;  // frame longer than 255 bytes
  } mfc_frame_t;

  // one classification result
  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_register;
    logic [15:0] register_count;
    logic [15:0] write_value;
    logic [7:0]  payload_length;
    logic [7:0]  payload_offset;
    logic [7:0]  exception_code;
  } mfc_result_t;

endpackage

// ===== rtl/core/modbus_frame_classifier_core.sv =====
// modbus_frame_classifier_core: top level with queue ports and the apb register
// depends on mfc_pkg, mfc_front, mfc_back and mfc_fifo

// Bytes of a modbus frame (crc removed) are pushed one per cycle, the final byte
// flagged by last_byte; each frame gives exactly one result on the pop side,
// classified as invalid, exception, request or response. Input is taken at one
// byte per clock while full is low. The front stage counts and captures bytes, a
// MID_DEPTH frame queue decouples it from the classifier, which handles one frame
// per cycle while the result queue has room and holds the pending request, and an
// OUT_DEPTH result queue drives the output ports. full rises only when the frame
// queue is full, i.e. while the result side has been stalled.
// broadcast_address lies at byte address 0 of the apb port.

module modbus_frame_classifier_core
  import mfc_pkg::*;
#(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // byte intake
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  frame_kind,
  output logic [7:0]  slave_address,
  output logic [7:0]  function_code,
  output logic [15:0] start_register,
  output logic [15:0] register_count,
  output logic [15:0] write_value,
  output logic [7:0]  payload_length,
  output logic [7:0]  payload_offset,
  output logic [7:0]  exception_code,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        take;
  mfc_frame_t  front_frame;
  logic        front_push;
  mfc_frame_t  mid_frame;
  logic        mid_empty;
  logic        mid_pop;
  mfc_result_t back_result;
  logic        back_push;
  logic        out_full;
  mfc_result_t out_result;
  logic [7:0]  broadcast_address;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BROADCAST_ADDRESS) ? {24'd0, broadcast_address} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      broadcast_address <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_BROADCAST_ADDRESS)) begin
      broadcast_address <= pwdata[7:0];
    end
  end

  // front: byte intake
  assign take = push && !full;

  mfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .frame      (front_frame),
    .frame_push (front_push)
  );

  // frame queue between front and back
  mfc_fifo #(
    .WIDTH ($bits(mfc_frame_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_push),
    .wr_data (front_frame),
    .full    (full),
    .rd_en   (mid_pop),
    .rd_data (mid_frame),
    .empty   (mid_empty)
  );

  // back: classification
  mfc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .frame_valid       (!mid_empty),
    .frame             (mid_frame),
    .frame_pop         (mid_pop),
    .broadcast_address (broadcast_address),
    .result_full       (out_full),
    .result            (back_result),
    .result_push       (back_push)
  );

  // result queue
  mfc_fifo #(
    .WIDTH ($bits(mfc_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_push),
    .wr_data (back_result),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_result),
    .empty   (empty)
  );

  assign frame_kind     = out_result.frame_kind;
  assign slave_address  = out_result.slave_address;
  assign function_code  = out_result.function_code;
  assign start_register = out_result.start_register;
  assign register_count = out_result.register_count;
  assign write_value    = out_result.write_value;
  assign payload_length = out_result.payload_length;
  assign payload_offset = out_result.payload_offset;
  assign exception_code = out_result.exception_code;

endmodule

// ===== rtl/core/mfc_fifo.sv =====
// mfc_fifo: small first-word-fall-through queue of registers
// generic width and depth; no package needed

module mfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             wr;
  logic             rd;

  // status and handshake qualification
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr      = wr_en && !full;
  assign rd      = rd_en && !empty;
  assign rd_data = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

  // fill count stays within depth
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("mfc_fifo: fill count beyond depth");

  // a request is only offered by the writer when space is free
  assert property (@(posedge clk) disable iff (rst) !(wr_en && full))
    else $error("mfc_fifo: write into full queue");

endmodule

// ===== rtl/core/mfc_front.sv =====
// mfc_front: byte intake, header capture, length count and overlong detection
// depends on mfc_pkg for the frame record type

module mfc_front
  import mfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output mfc_frame_t frame,
  output logic       frame_push
);

  logic [7:0] header_store [HDR_DEPTH];
  logic [7:0] byte_count;
  logic       overlong_flag;
  logic [7:0] len;

  assign len        = byte_count + 8'd1;
  assign frame_push = take && last_byte;

  // frame record: current byte merged in, bytes beyond the length read as zero
  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      if (8'(i) >= len) begin
        frame.hdr[i] = '0;
      end else if (byte_count == 8'(i)) begin
        frame.hdr[i] = data_byte;
      end else begin
        frame.hdr[i] = header_store[i];
      end
    end
    frame.len  = len;
    frame.over = overlong_flag || (byte_count == 8'hFF);
  end

  // header capture
  always_ff @(posedge clk) begin
    if (take && (byte_count < 8'(HDR_DEPTH))) begin
      header_store[byte_count[2:0]] <= data_byte;
    end
  end

  // byte count and overlong flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      overlong_flag <= 1'b0;
    end else if (take) begin
      if (last_byte) begin
        byte_count    <= '0;
        overlong_flag <= 1'b0;
      end else if (byte_count == 8'hFF) begin
        overlong_flag <= 1'b1;
      end else begin
        byte_count <= byte_count + 8'd1;
      end
    end
  end

  // the last byte always restarts the count
  assert property (@(posedge clk) disable iff (rst)
    (take && last_byte) |=> (byte_count == '0 && !overlong_flag))
    else $error("mfc_front: count not cleared after last byte");

endmodule

// ===== rtl/core/mfc_back.sv =====
// mfc_back: classifies one queued frame per cycle while result_full is low and
// tracks the pending request; depends on mfc_pkg types and function codes

module mfc_back
  import mfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        frame_valid,
  input  mfc_frame_t  frame,
  output logic        frame_pop,
  input  logic [7:0]  broadcast_address,
  input  logic        result_full,
  output mfc_result_t result,
  output logic        result_push
);

  logic [7:0]  pending_address;
  logic [7:0]  pending_function;
  logic [15:0] pending_register;
  logic        set_pending;
  logic        clear_pending;
  logic [7:0]  h [HDR_DEPTH];
  logic        is_read;
  logic        match;

  assign frame_pop   = frame_valid && !result_full;
  assign result_push = frame_pop;

  always_comb begin
    for (int i = 0; i < HDR_DEPTH; i++) begin
      h[i] = frame.hdr[i];
    end
  end

  assign is_read = (h[1] == FUNC_READ_HOLDING) || (h[1] == FUNC_READ_INPUT);
  assign match   = (h[0] == pending_address) && (h[1] == pending_function);

  // classification
  always_comb begin
    result        = '0;
    set_pending   = 1'b0;
    clear_pending = 1'b0;
    if (frame.over) begin
      result.frame_kind = KIND_INVALID;
    end else if (frame.len == 8'd3) begin
      result.frame_kind     = KIND_EXCEPTION;
      result.slave_address  = h[0];
      result.function_code  = h[1];
      result.exception_code = h[2];
    end else if (frame.len >= 8'd5) begin
      result.slave_address = h[0];
      result.function_code = h[1];
      if (is_read) begin
        if (frame.len == 8'd6) begin
          result.frame_kind     = KIND_REQUEST;
          result.start_register = {h[2], h[3]};
          result.register_count = {h[4], h[5]};
        end else begin
          result.payload_length = h[2];
          if (h[2] == frame.len - 8'd3) begin
            result.frame_kind = KIND_RESPONSE;
          end
        end
      end else if (h[1] == FUNC_WRITE_SINGLE) begin
        if (frame.len == 8'd6) begin
          result.start_register = {h[2], h[3]};
          result.register_count = 16'd1;
          result.write_value    = {h[4], h[5]};
          if (match && (h[0] != broadcast_address)) begin
            result.frame_kind = KIND_RESPONSE;
          end else begin
            result.frame_kind = KIND_REQUEST;
          end
        end
      end else if (h[1] == FUNC_WRITE_MULTIPLE) begin
        result.start_register = {h[2], h[3]};
        result.register_count = {h[4], h[5]};
        if (frame.len == 8'd6) begin
          result.frame_kind = KIND_RESPONSE;
        end else if (frame.len >= 8'd7) begin
          result.payload_length = h[6];
          if (h[6] == frame.len - 8'd7) begin
            result.frame_kind = KIND_REQUEST;
          end
        end
      end

      // pending request bookkeeping
      if (result.frame_kind == KIND_REQUEST) begin
        set_pending = 1'b1;
      end else if (result.frame_kind == KIND_RESPONSE) begin
        clear_pending = 1'b1;
        if (match && is_read) begin
          result.start_register = pending_register;
        end
      end

      // payload offset for valid frames with a data block
      if ((result.frame_kind != KIND_INVALID) && (result.payload_length != '0)) begin
        result.payload_offset = frame.len - result.payload_length;
      end
    end
  end

  // pending request registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_address  <= '0;
      pending_function <= '0;
      pending_register <= '0;
    end else if (frame_pop) begin
      if (set_pending) begin
        pending_address  <= h[0];
        pending_function <= h[1];
        pending_register <= {h[2], h[3]};
      end else if (clear_pending) begin
        pending_address  <= '0;
        pending_function <= '0;
        pending_register <= '0;
      end
    end
  end

  // a taken response leaves no pending request behind
  assert property (@(posedge clk) disable iff (rst)
    (frame_pop && result.frame_kind == KIND_RESPONSE) |=>
      (pending_address == '0 && pending_function == '0 && pending_register == '0))
    else $error("mfc_back: pending request kept after response");

endmodule

// ===== tb/sv/mfc_frame_checker.sv =====
// mfc_frame_checker: watches the byte, result and register ports of the classifier,
// predicts one result per frame and compares it field by field with what is popped
// depends on mfc_pkg only

module mfc_frame_checker
  import mfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  frame_kind,
  input  logic [7:0]  slave_address,
  input  logic [7:0]  function_code,
  input  logic [15:0] start_register,
  input  logic [15:0] register_count,
  input  logic [15:0] write_value,
  input  logic [7:0]  payload_length,
  input  logic [7:0]  payload_offset,
  input  logic [7:0]  exception_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count,
  output int          results_checked,
  output int          results_waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  // own copy of the classifier state
  logic [7:0]  hdr_bytes [HDR_DEPTH];
  logic [7:0]  bytes_in_frame = 8'd0;
  logic        frame_too_long = 1'b0;
  logic [7:0]  pend_addr = 8'd0;
  logic [7:0]  pend_func = 8'd0;
  logic [15:0] pend_reg = 16'd0;
  logic [7:0]  bcast_addr = 8'd0;

  mfc_result_t expected_frames [$];
  mfc_result_t want;
  int          n_fail = 0;
  int          n_checked = 0;

  // header byte, zero beyond the frame or the kept bytes
  function automatic logic [7:0] hdr_at(input int idx, input int flen);
    if (idx >= flen || idx >= HDR_DEPTH) return 8'h00;
    return hdr_bytes[idx[2:0]];
  endfunction

  // absorb one byte; on the marked byte, queue the classification of the frame
  task automatic classify_byte(input logic [7:0] b, input logic lb);
    mfc_result_t r;
    int          flen;
    int          diff;
    logic        pend_done;
    r = '0;
    pend_done = 1'b0;
    if (bytes_in_frame < 8'(HDR_DEPTH)) hdr_bytes[bytes_in_frame[2:0]] = b;
    if (!lb) begin
      if (bytes_in_frame == 8'd255) frame_too_long = 1'b1;
      else bytes_in_frame = bytes_in_frame + 8'd1;
    end else begin
      flen = int'(bytes_in_frame) + 1;
      if (!frame_too_long && flen <= 255) begin
        if (flen == 3) begin
          r.frame_kind     = KIND_EXCEPTION;
          r.slave_address  = hdr_at(0, flen);
          r.function_code  = hdr_at(1, flen);
          r.exception_code = hdr_at(2, flen);
        end else if (flen >= 5) begin
          r.slave_address = hdr_at(0, flen);
          r.function_code = hdr_at(1, flen);
          case (r.function_code)
            FUNC_READ_HOLDING, FUNC_READ_INPUT: begin
              if (flen == 6) begin
                r.frame_kind     = KIND_REQUEST;
                r.start_register = {hdr_at(2, flen), hdr_at(3, flen)};
                r.register_count = {hdr_at(4, flen), hdr_at(5, flen)};
              end else begin
                r.payload_length = hdr_at(2, flen);
                if (int'(r.payload_length) == flen - 3) r.frame_kind = KIND_RESPONSE;
              end
            end
            FUNC_WRITE_SINGLE: begin
              if (flen == 6) begin
                pend_done        = 1'b1;
                r.start_register = {hdr_at(2, flen), hdr_at(3, flen)};
                r.register_count = 16'd1;
                r.write_value    = {hdr_at(4, flen), hdr_at(5, flen)};
                // an echo of the pending write is the answer, unless it is broadcast
                if (r.slave_address == pend_addr && r.function_code == pend_func &&
                    r.slave_address != bcast_addr) begin
                  r.frame_kind = KIND_RESPONSE;
                  pend_addr = 8'd0;
                  pend_func = 8'd0;
                  pend_reg  = 16'd0;
                end else begin
                  r.frame_kind = KIND_REQUEST;
                  pend_addr = r.slave_address;
                  pend_func = r.function_code;
                  pend_reg  = r.start_register;
                end
              end
            end
            FUNC_WRITE_MULTIPLE: begin
              r.start_register = {hdr_at(2, flen), hdr_at(3, flen)};
              r.register_count = {hdr_at(4, flen), hdr_at(5, flen)};
              if (flen == 6) begin
                r.frame_kind = KIND_RESPONSE;
              end else begin
                r.payload_length = hdr_at(6, flen);
                if (int'(r.payload_length) == flen - 7) r.frame_kind = KIND_REQUEST;
              end
            end
            default: ;
          endcase
          // remember requests; answers take the register of a matching read
          if (!pend_done) begin
            if (r.frame_kind == KIND_REQUEST) begin
              pend_addr = r.slave_address;
              pend_func = r.function_code;
              pend_reg  = r.start_register;
            end else if (r.frame_kind == KIND_RESPONSE) begin
              if (r.slave_address == pend_addr && r.function_code == pend_func &&
                  (r.function_code == FUNC_READ_HOLDING ||
                   r.function_code == FUNC_READ_INPUT))
                r.start_register = pend_reg;
              pend_addr = 8'd0;
              pend_func = 8'd0;
              pend_reg  = 16'd0;
            end
          end
          if (r.frame_kind != KIND_INVALID && r.payload_length != 8'd0) begin
            diff = flen - int'(r.payload_length);
            r.payload_offset = diff[7:0];
          end
        end
      end
      bytes_in_frame = 8'd0;
      frame_too_long = 1'b0;
      expected_frames.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      n_fail++;
    end
  endtask

  // results are compared before this edge's byte is absorbed
  always @(posedge clk) begin
    if (rst) begin
      expected_frames.delete();
      bytes_in_frame = 8'd0;
      frame_too_long = 1'b0;
      pend_addr  = 8'd0;
      pend_func  = 8'd0;
      pend_reg   = 16'd0;
      bcast_addr = 8'd0;
    end else begin
      if (pop && !empty) begin
        if (expected_frames.size() == 0) begin
          $error("result popped while no frame was outstanding");
          n_fail++;
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_kind", 32'(want.frame_kind), 32'(frame_kind));
          check_field("slave_address", 32'(want.slave_address), 32'(slave_address));
          check_field("function_code", 32'(want.function_code), 32'(function_code));
          check_field("start_register", 32'(want.start_register), 32'(start_register));
          check_field("register_count", 32'(want.register_count), 32'(register_count));
          check_field("write_value", 32'(want.write_value), 32'(write_value));
          check_field("payload_length", 32'(want.payload_length), 32'(payload_length));
          check_field("payload_offset", 32'(want.payload_offset), 32'(payload_offset));
          check_field("exception_code", 32'(want.exception_code), 32'(exception_code));
          n_checked++;
        end
      end
      if (push && !full) classify_byte(data_byte, last_byte);
      // register access phase
      if (psel && penable && pready && paddr[2] == REG_BROADCAST_ADDRESS) begin
        if (pwrite) bcast_addr = pwdata[7:0];
        else check_field("prdata", {24'h0, bcast_addr}, prdata);
      end
    end
    fail_count      <= n_fail;
    results_checked <= n_checked;
    results_waiting <= expected_frames.size();
  end

endmodule

// ===== tb/sv/modbus_frame_classifier_core_tb.sv =====
// modbus_frame_classifier_core_tb: clock, reset, frame and register stimulus, verdict
// depends on mfc_pkg, modbus_frame_classifier_core and mfc_frame_checker

module modbus_frame_classifier_core_tb
  import mfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 6;
  localparam int PHASE_BYTES = 305;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  frame_kind;
  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [15:0] start_register;
  logic [15:0] register_count;
  logic [15:0] write_value;
  logic [7:0]  payload_length;
  logic [7:0]  payload_offset;
  logic [7:0]  exception_code;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int results_checked;
  int results_waiting;

  int         send_idle = 29;
  int         recv_idle = 82;
  int         bytes_sent = 0;
  int         frames_sent = 0;
  int         settings_written = 0;
  int         phase_start;
  int         stall_cycles = 0;
  logic [7:0] bcast_now = 8'h00;
  logic [7:0] frame_buf [$];

  modbus_frame_classifier_core dut (.*);

  mfc_frame_checker frame_check (.*);

  always #1 clk = ~clk;

  // result side: pop at random according to the current stall rate
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99, 0) >= recv_idle);
  end

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("modbus_frame_classifier_core test failed");
      $finish;
    end
  end

  // offer one byte, with a random gap before it, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic lb);
    if ($urandom_range(99, 0) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= lb;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // let every outstanding result drain, then pause with no input
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {REG_BROADCAST_ADDRESS, 2'b00};
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put(input logic [7:0] b);
    frame_buf.push_back(b);
  endtask

  task automatic begin_frame(input logic [7:0] a, input logic [7:0] f);
    frame_buf.delete();
    put(a);
    put(f);
  endtask

  function automatic logic [7:0] any_byte();
    int sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(255, 0));
  endfunction

  task automatic add_bytes(input int n);
    for (int i = 0; i < n; i++) put(any_byte());
  endtask

  // a few addresses dominate so that answers meet their requests
  function automatic logic [7:0] pick_addr();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 40) return 8'($urandom_range(3, 1));
    if (sel < 55) return bcast_now;
    if (sel < 62) return sel[0] ? 8'hFF : 8'h00;
    return 8'($urandom_range(255, 0));
  endfunction

  // one random exchange: mostly well-formed request/answer pairs, some broken frames
  task automatic random_round();
    logic [7:0] a;
    logic [7:0] f;
    int         sel;
    int         n;
    sel = $urandom_range(99, 0);
    a   = pick_addr();
    if (sel < 25) begin
      // read request, usually answered
      f = $urandom_range(1, 0) ? FUNC_READ_HOLDING : FUNC_READ_INPUT;
      begin_frame(a, f);
      add_bytes(4);
      send_frame();
      if ($urandom_range(4, 0) != 0) begin
        if ($urandom_range(4, 0) == 0) a = pick_addr();
        n = $urandom_range(24, 2);
        if (n == 3) n = 2;
        begin_frame(a, f);
        put(8'(n));
        add_bytes(n);
        send_frame();
      end
    end else if (sel < 45) begin
      // write single, echoed back in most cases
      begin_frame(a, FUNC_WRITE_SINGLE);
      add_bytes(4);
      send_frame();
      if ($urandom_range(3, 0) != 0) send_frame();
    end else if (sel < 60) begin
      // write multiple and its short acknowledgement
      n = $urandom_range(16, 0);
      begin_frame(a, FUNC_WRITE_MULTIPLE);
      add_bytes(4);
      put(8'(n));
      add_bytes(n);
      send_frame();
      if ($urandom_range(9, 0) < 7) begin
        while (frame_buf.size() > 6) frame_buf.delete(frame_buf.size() - 1);
        send_frame();
      end
    end else if (sel < 68) begin
      // exception answer
      begin_frame(a, any_byte() | 8'h80);
      put(any_byte());
      send_frame();
    end else if (sel < 74) begin
      // one, two or four bytes
      n = $urandom_range(2, 0);
      n = (n == 2) ? 4 : n + 1;
      frame_buf.delete();
      add_bytes(n);
      send_frame();
    end else if (sel < 88) begin
      // known function with odd length or a byte count near the right one
      case ($urandom_range(3, 0))
        0: f = FUNC_READ_HOLDING;
        1: f = FUNC_READ_INPUT;
        2: f = FUNC_WRITE_SINGLE;
        default: f = FUNC_WRITE_MULTIPLE;
      endcase
      n = $urandom_range(14, 5);
      begin_frame(a, f);
      add_bytes(n - 2);
      if ($urandom_range(1, 0) != 0) begin
        if (f == FUNC_READ_HOLDING || f == FUNC_READ_INPUT)
          frame_buf[2] = 8'(n - 3 + ($urandom_range(1, 0) ? 1 : -1));
        else if (f == FUNC_WRITE_MULTIPLE && n >= 7)
          frame_buf[6] = 8'(n - 7 + ($urandom_range(1, 0) ? 1 : -1));
      end
      send_frame();
    end else begin
      // noise
      frame_buf.delete();
      add_bytes($urandom_range(12, 1));
      send_frame();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: single byte, exception, write echo pair, short write multiple,
    // and a five-byte frame whose missing header byte reads as zero
    frame_buf.delete();
    put(8'hFF);
    send_frame();
    begin_frame(8'h00, 8'h83);
    put(8'hFF);
    send_frame();
    begin_frame(8'h11, FUNC_WRITE_SINGLE);
    put(8'hFF);
    put(8'hFF);
    put(8'h00);
    put(8'h00);
    send_frame();
    send_frame();
    begin_frame(8'hFF, FUNC_WRITE_MULTIPLE);
    put(8'h00);
    put(8'h00);
    put(8'hFF);
    put(8'hFF);
    send_frame();
    begin_frame(8'h01, FUNC_WRITE_MULTIPLE);
    put(8'h00);
    put(8'h02);
    put(8'h00);
    send_frame();
    settle();

    // random phases, each with a broadcast address of its own; pairs of phases share a stall pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_idle = 29;
          recv_idle = 82;
        end
        1: begin
          send_idle = 82;
          recv_idle = 29;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      case (ph)
        0: bcast_now = 8'hFF;
        1: bcast_now = 8'h00;
        2: bcast_now = 8'h02;
        4: bcast_now = 8'h01;
        default: bcast_now = 8'($urandom_range(255, 0));
      endcase
      apb_access(1'b1, bcast_now);
      apb_access(1'b0, 8'h00);
      settings_written++;
      phase_start = bytes_sent;
      if (ph == 4) begin
        // longest frame still accepted: a read answer of 255 bytes
        begin_frame(pick_addr(), FUNC_READ_HOLDING);
        put(8'd252);
        add_bytes(252);
        send_frame();
      end else if (ph == 5) begin
        // frame beyond 255 bytes
        begin_frame(any_byte(), any_byte());
        add_bytes($urandom_range(268, 254));
        send_frame();
      end
      while (bytes_sent - phase_start < PHASE_BYTES) random_round();
      settle();
    end

    $display("run covered %0d bytes in %0d frames, %0d results compared",
             bytes_sent, frames_sent, results_checked);
    $display("%0d broadcast settings, with sender and receiver stalls in turn and none",
             settings_written);
    if (fail_count == 0 && results_waiting == 0)
      $display("modbus_frame_classifier_core test passed");
    else
      $display("modbus_frame_classifier_core test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mfc_pkg.sv
rtl/core/mfc_fifo.sv
rtl/core/mfc_front.sv
rtl/core/mfc_back.sv
rtl/core/modbus_frame_classifier_core.sv
tb/sv/mfc_frame_checker.sv
tb/sv/modbus_frame_classifier_core_tb.sv
